// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the buffer cache rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== rtl/core/bbc_pkg.sv =====
// package with constants, codes and types of the buffer cache tag engine
package bbc_pkg;

   localparam int SLOTS = 30;
   localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_PIN     = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_MISS   = 2'd1;
   localparam logic [1:0] STAT_NOFREE = 2'd2;
   localparam logic [1:0] STAT_ERROR  = 2'd3;

   typedef struct packed {
      logic        used;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic        valid;
      logic [7:0]  count;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic             match_found;
      logic [SlotW-1:0] match_idx;
      logic             free_found;
      logic [SlotW-1:0] free_idx;
   } scan_result_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

endpackage

// ===== rtl/core/bbc_slot_store.sv =====
// per-slot tag, count and timestamp registers with one read and one write port
module bbc_slot_store
   import bbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [SlotW-1:0] rd_idx,
   output entry_type        rd_entry,
   input  logic             wr_en,
   input  logic [SlotW-1:0] wr_idx,
   input  entry_type        wr_entry
);

   logic        used_ff   [SLOTS];
   logic [7:0]  device_ff [SLOTS];
   logic [31:0] block_ff  [SLOTS];
   logic        valid_ff  [SLOTS];
   logic [7:0]  count_ff  [SLOTS];
   logic [31:0] stamp_ff  [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i]  <= 1'b0;
            valid_ff[i] <= 1'b0;
            count_ff[i] <= 8'd0;
            stamp_ff[i] <= 32'd0;
         end
      end else if (wr_en) begin
         used_ff[wr_idx]  <= wr_entry.used;
         valid_ff[wr_idx] <= wr_entry.valid;
         count_ff[wr_idx] <= wr_entry.count;
         stamp_ff[wr_idx] <= wr_entry.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         device_ff[wr_idx] <= wr_entry.device;
         block_ff[wr_idx]  <= wr_entry.block_number;
      end
   end

   always_comb begin
      rd_entry.used         = used_ff[rd_idx];
      rd_entry.device       = device_ff[rd_idx];
      rd_entry.block_number = block_ff[rd_idx];
      rd_entry.valid        = valid_ff[rd_idx];
      rd_entry.count        = count_ff[rd_idx];
      rd_entry.stamp        = stamp_ff[rd_idx];
   end

endmodule

// ===== rtl/core/bbc_scan_unit.sv =====
// shared compare unit: tag match and oldest free slot, one slot per cycle
`include "assert_macros.svh"
module bbc_scan_unit
   import bbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             step,
   input  logic [SlotW-1:0] idx,
   input  entry_type        entry,
   input  logic [7:0]       key_device,
   input  logic [31:0]      key_block,
   output logic             hit,
   output scan_result_type  result
);

   logic             match_found_ff, match_found_in;
   logic [SlotW-1:0] match_idx_ff, match_idx_in;
   logic             free_found_ff, free_found_in;
   logic [SlotW-1:0] free_idx_ff, free_idx_in;
   logic [31:0]      free_stamp_ff, free_stamp_in;
   logic             better_free;

   assign hit = step && entry.used && (entry.device == key_device)
                && (entry.block_number == key_block);

   assign better_free = (entry.count == 8'd0)
                        && (!free_found_ff || (entry.stamp < free_stamp_ff));

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      free_stamp_in  = free_stamp_ff;
      if (start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end else if (step) begin
         if (hit) begin
            match_found_in = 1'b1;
            match_idx_in   = idx;
         end
         if (better_free) begin
            free_found_in = 1'b1;
            free_idx_in   = idx;
            free_stamp_in = entry.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      free_stamp_ff <= free_stamp_in;
   end

   assign result.match_found = match_found_ff;
   assign result.match_idx   = match_idx_ff;
   assign result.free_found  = free_found_ff;
   assign result.free_idx    = free_idx_ff;

   `ASSERT_NEVER(a_no_start_and_step, clock, reset, start && step)
   `ASSERT_CLK(a_free_only_on_zero, clock, reset,
      $rose(free_found_ff) |-> $past(entry.count == 8'd0))

endmodule

// ===== rtl/core/block_buffer_cache_lru_core.sv =====
// top level of the buffer cache tag engine: sequencer, clock and result register
// usage:
//   req channel carries one request word: operation in req_tuser, device,
//   block number and slot in req_tdata. rsp channel returns exactly one
//   result word per request: status in rsp_tuser, slot, read flag and
//   reference count in rsp_tdata.
//   a read request walks the slots one per cycle through a shared compare
//   unit, stopping early on a tag match, and then enters the finishing step,
//   which loads the result register.
//   pin, release and unknown requests go straight to the finishing step.
//   req_tready is high only while the sequencer is idle, so one request is
//   in flight at a time; the next request can be taken in the cycle after
//   the result is loaded.
//   a new request may be taken while the previous result still waits in
//   the output register.
//   if the receiver stalls, the finished request holds in its last step
//   until the output register is free; no state changes before that.
//   reset empties every slot, clears counts, stamps and the use clock.
`include "assert_macros.svh"
module block_buffer_cache_lru_core
   import bbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // device[7:0], block_number[39:8], slot[45:40], zero pad
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // result_slot[5:0], needs_read[6], ref_count[14:7], zero pad
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam logic [6:0]       SlotsLimit = 7'(SLOTS);
   localparam logic [SlotW-1:0] LastIdx    = SlotW'(SLOTS - 1);

   state_type        state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [7:0]       device_ff, device_in;
   logic [31:0]      block_ff, block_in;
   logic [5:0]       slot_ff, slot_in;
   logic [SlotW-1:0] scan_idx_ff, scan_idx_in;
   logic [31:0]      use_clock_ff, use_clock_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [5:0]       rsp_slot_ff, rsp_slot_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_read_ff, rsp_read_in;
   logic [7:0]       rsp_count_ff, rsp_count_in;

   logic             accept;
   logic             out_free;
   logic             fin_go;
   logic             scan_start;
   logic             scan_step;
   logic             scan_hit;
   scan_result_type  scan_res;
   logic [SlotW-1:0] rd_idx;
   entry_type        rd_entry;
   logic             wr_en;
   logic             fin_write;
   entry_type        wr_entry;
   logic             bump_clock;
   logic             in_range;
   logic [5:0]       res_slot;
   logic [1:0]       res_status;
   logic             res_read;
   logic [7:0]       res_count;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fin_go     = (state_ff == S_FINISH) && out_free;
   assign scan_start = accept;
   assign scan_step  = (state_ff == S_SCAN);
   assign in_range   = ({1'b0, slot_ff} < SlotsLimit);

   always_comb begin
      if (state_ff == S_SCAN) begin
         rd_idx = scan_idx_ff;
      end else if (op_ff == OP_READ) begin
         rd_idx = scan_res.match_found ? scan_res.match_idx : scan_res.free_idx;
      end else begin
         rd_idx = slot_ff[SlotW-1:0];
      end
   end

   bbc_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (rd_idx),
      .wr_entry (wr_entry)
   );

   bbc_scan_unit u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .step       (scan_step),
      .idx        (scan_idx_ff),
      .entry      (rd_entry),
      .key_device (device_ff),
      .key_block  (block_ff),
      .hit        (scan_hit),
      .result     (scan_res)
   );

   // result and slot update of the finishing step
   always_comb begin
      wr_entry   = rd_entry;
      fin_write  = 1'b0;
      bump_clock = 1'b0;
      res_slot   = 6'(rd_idx);
      res_status = STAT_DONE;
      res_read   = 1'b0;
      res_count  = 8'd0;
      case (op_ff)
         OP_READ: begin
            if (scan_res.match_found) begin
               if (rd_entry.count == COUNT_MAX) begin
                  res_status = STAT_ERROR;
                  res_count  = COUNT_MAX;
               end else begin
                  wr_entry.count = rd_entry.count + 8'd1;
                  wr_entry.valid = 1'b1;
                  fin_write      = 1'b1;
                  res_read       = !rd_entry.valid;
                  res_count      = rd_entry.count + 8'd1;
               end
            end else if (scan_res.free_found) begin
               wr_entry.used         = 1'b1;
               wr_entry.device       = device_ff;
               wr_entry.block_number = block_ff;
               wr_entry.valid        = 1'b1;
               wr_entry.count        = 8'd1;
               wr_entry.stamp        = use_clock_ff;
               fin_write             = 1'b1;
               bump_clock            = 1'b1;
               res_status            = STAT_MISS;
               res_read              = 1'b1;
               res_count             = 8'd1;
            end else begin
               res_slot   = 6'd0;
               res_status = STAT_NOFREE;
            end
         end
         OP_PIN: begin
            if (!in_range) begin
               res_slot   = slot_ff;
               res_status = STAT_ERROR;
            end else if (rd_entry.count == COUNT_MAX) begin
               res_status = STAT_ERROR;
               res_count  = COUNT_MAX;
            end else begin
               wr_entry.count = rd_entry.count + 8'd1;
               fin_write      = 1'b1;
               res_count      = rd_entry.count + 8'd1;
            end
         end
         OP_RELEASE: begin
            if (!in_range) begin
               res_slot   = slot_ff;
               res_status = STAT_ERROR;
            end else if (rd_entry.count == 8'd0) begin
               res_status = STAT_ERROR;
            end else begin
               wr_entry.count = rd_entry.count - 8'd1;
               fin_write      = 1'b1;
               res_count      = rd_entry.count - 8'd1;
               if (rd_entry.count == 8'd1) begin
                  wr_entry.stamp = use_clock_ff;
                  bump_clock     = 1'b1;
               end
            end
         end
         default: begin
            res_slot   = 6'd0;
            res_status = STAT_ERROR;
         end
      endcase
   end

   assign wr_en = fin_go && fin_write;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      device_in    = device_ff;
      block_in     = block_ff;
      slot_in      = slot_ff;
      scan_idx_in  = scan_idx_ff;
      use_clock_in = use_clock_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_tuser;
               device_in   = req_tdata[7:0];
               block_in    = req_tdata[39:8];
               slot_in     = req_tdata[45:40];
               scan_idx_in = '0;
               state_in    = (req_tuser == OP_READ) ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (scan_hit || (scan_idx_ff == LastIdx)) begin
               state_in = S_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + SlotW'(1);
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot;
               rsp_status_in = res_status;
               rsp_read_in   = res_read;
               rsp_count_in  = res_count;
               if (bump_clock) begin
                  use_clock_in = use_clock_ff + 32'd1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         use_clock_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         use_clock_ff <= use_clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      device_ff     <= device_in;
      block_ff      <= block_in;
      slot_ff       <= slot_in;
      scan_idx_ff   <= scan_idx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_read_ff, rsp_slot_ff};

   `ASSERT_CLK(a_result_from_finish, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
   `ASSERT_CLK(a_clock_steps_by_one, clock, reset,
      ($past(!reset) && (use_clock_ff != $past(use_clock_ff)))
         |-> (use_clock_ff == $past(use_clock_ff) + 32'd1))
   `ASSERT_CLK(a_write_only_when_done, clock, reset,
      wr_en |-> ((state_ff == S_FINISH) && out_free))

endmodule
